// File: hw/rtl/ash_frame_decoder_top_defines.svh
// Assertion macros shared by the frame decoder checker.
// Each macro expands to one labeled concurrent assertion on a clock and a reset.
`ifndef ASH_FRAME_DECODER_TOP_DEFINES_SVH
`define ASH_FRAME_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define ASH_FD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ash_fd: same-cycle check failed");

// next-cycle implication
`define ASH_FD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ash_fd: next-cycle check failed");

`endif

// File: hw/rtl/ash_fd_pkg.sv
// Types, constants and the CRC step for the frame decoder.
// No dependencies; used by all decoder modules but the RAM.
`timescale 1ns / 1ps

package ash_fd_pkg;

   localparam logic [7:0]  FLAG_BYTE = 8'h7E;
   localparam logic [7:0]  ESC_BYTE  = 8'h7D;
   localparam logic [7:0]  ESC_XOR   = 8'h20;
   localparam logic [15:0] CRC_POLY  = 16'h1021;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;

   localparam int RAW_W  = 10;
   localparam int PLEN_W = 6;
   localparam int CAP_W  = 6;

   localparam logic [RAW_W-1:0] RAW_SAT   = 10'd1023;
   localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

   // register index taken from address bit 2
   localparam logic REG_CAPACITY = 1'b0;

   typedef enum logic [2:0] {
      STATUS_OK    = 3'd0,
      STATUS_ESC   = 3'd1,
      STATUS_LONG  = 3'd2,
      STATUS_SHORT = 3'd3,
      STATUS_CRC   = 3'd4,
      STATUS_CAP   = 3'd5
   } status_type;

   // one finished frame handed from the front to the back
   typedef struct packed {
      logic              bank;
      status_type        status;
      logic [PLEN_W-1:0] plen;
      logic [RAW_W-1:0]  raw;
   } desc_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: hw/rtl/ash_fd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ash_fd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/ash_fd_front.sv
// Front end: unstuffs raw bytes, runs the CRC, writes the frame bank, classifies at the flag.
// Depends on ash_fd_pkg.
`timescale 1ns / 1ps

module ash_fd_front #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic [7:0]                              req_raw_byte,
   output logic                                    req_stall,
   input  logic [ash_fd_pkg::CAP_W-1:0]            capacity,
   output logic                                    ram_we,
   output logic [$clog2(MAX_PAYLOAD+3):0]          ram_waddr,
   output logic [7:0]                              ram_wdata,
   output logic                                    q_push,
   output ash_fd_pkg::desc_type                    q_data,
   input  logic                                    frame_done
);

   localparam int STORE_DEPTH = MAX_PAYLOAD + 3;
   localparam int IW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int CMP_W = (CW > ash_fd_pkg::CAP_W) ? CW : ash_fd_pkg::CAP_W;

   logic [CW-1:0]                   count_ff, count_in;
   logic                            esc_ff, esc_in;
   logic                            ovf_ff, ovf_in;
   logic [ash_fd_pkg::RAW_W-1:0]    raw_ff, raw_in, raw_next;
   logic [15:0]                     crc_ff, crc_in;
   logic [7:0]                      last1_ff, last1_in, last2_ff, last2_in;
   logic                            bank_ff, bank_in;
   logic [1:0]                      frames_ff, frames_in;
   logic                            accept;
   logic [7:0]                      byte_dec;
   logic [CW-1:0]                   plen_full;
   ash_fd_pkg::status_type          status;

   // both banks hold frames not yet drained
   assign req_stall = (frames_ff == 2'd2);
   assign accept    = req_valid && !req_stall;

   assign raw_next  = (raw_ff == ash_fd_pkg::RAW_SAT) ? raw_ff : raw_ff + 1'b1;
   assign byte_dec  = esc_ff ? (req_raw_byte ^ ash_fd_pkg::ESC_XOR) : req_raw_byte;
   assign plen_full = count_ff - CW'(3);

   always_comb begin
      if (ovf_ff) begin
         status = ash_fd_pkg::STATUS_LONG;
      end else if (esc_ff) begin
         status = ash_fd_pkg::STATUS_ESC;
      end else if (count_ff < CW'(3)) begin
         status = ash_fd_pkg::STATUS_SHORT;
      end else if ({last2_ff, last1_ff} != crc_ff) begin
         status = ash_fd_pkg::STATUS_CRC;
      end else if (CMP_W'(plen_full) > CMP_W'(capacity)) begin
         status = ash_fd_pkg::STATUS_CAP;
      end else begin
         status = ash_fd_pkg::STATUS_OK;
      end
   end

   always_comb begin
      q_data.bank   = bank_ff;
      q_data.status = status;
      q_data.plen   = (status == ash_fd_pkg::STATUS_OK) ?
                      ash_fd_pkg::PLEN_W'(plen_full) : '0;
      q_data.raw    = raw_next;
   end

   always_comb begin
      count_in  = count_ff;
      esc_in    = esc_ff;
      ovf_in    = ovf_ff;
      raw_in    = raw_ff;
      crc_in    = crc_ff;
      last1_in  = last1_ff;
      last2_in  = last2_ff;
      bank_in   = bank_ff;
      ram_we    = 1'b0;
      q_push    = 1'b0;
      ram_waddr = {bank_ff, count_ff[IW-1:0]};
      ram_wdata = byte_dec;
      if (accept) begin
         raw_in = raw_next;
         if (req_raw_byte == ash_fd_pkg::FLAG_BYTE) begin
            // close the frame and start over in the other bank
            q_push   = 1'b1;
            count_in = '0;
            esc_in   = 1'b0;
            ovf_in   = 1'b0;
            raw_in   = '0;
            crc_in   = ash_fd_pkg::CRC_INIT;
            bank_in  = ~bank_ff;
         end else if (req_raw_byte == ash_fd_pkg::ESC_BYTE && !esc_ff) begin
            esc_in = 1'b1;
         end else begin
            esc_in = 1'b0;
            if (ovf_ff || count_ff >= CW'(STORE_DEPTH)) begin
               ovf_in = 1'b1;
            end else begin
               ram_we   = 1'b1;
               // CRC trails the store by two bytes
               if (count_ff >= CW'(2)) begin
                  crc_in = ash_fd_pkg::crc_feed(crc_ff, last2_ff);
               end
               last2_in = last1_ff;
               last1_in = byte_dec;
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   assign frames_in = frames_ff + {1'b0, q_push} - {1'b0, frame_done};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         esc_ff    <= 1'b0;
         ovf_ff    <= 1'b0;
         raw_ff    <= '0;
         crc_ff    <= ash_fd_pkg::CRC_INIT;
         bank_ff   <= 1'b0;
         frames_ff <= '0;
      end else begin
         count_ff  <= count_in;
         esc_ff    <= esc_in;
         ovf_ff    <= ovf_in;
         raw_ff    <= raw_in;
         crc_ff    <= crc_in;
         bank_ff   <= bank_in;
         frames_ff <= frames_in;
      end
      last1_ff <= last1_in;
      last2_ff <= last2_in;
   end

endmodule

// File: hw/rtl/ash_fd_queue.sv
// Two-entry queue of frame descriptors between the front and back ends.
// Depends on ash_fd_pkg.
`timescale 1ns / 1ps

module ash_fd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ash_fd_pkg::desc_type push_data,
   input  logic                 pop,
   output ash_fd_pkg::desc_type head,
   output logic                 empty
);

   ash_fd_pkg::desc_type entries_ff [2];
   logic                 wptr_ff, wptr_in;
   logic                 rptr_ff, rptr_in;
   logic [1:0]           count_ff, count_in;

   assign empty   = (count_ff == 2'd0);
   assign head    = entries_ff[rptr_ff];
   assign wptr_in = push ? ~wptr_ff : wptr_ff;
   assign rptr_in = pop ? ~rptr_ff : rptr_ff;
   assign count_in = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entries_ff[wptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/ash_fd_back.sv
// Back end: drains one frame descriptor at a time into the result register.
// Depends on ash_fd_pkg; reads the frame bank through the decoder RAM.
`timescale 1ns / 1ps

module ash_fd_back #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_empty,
   input  ash_fd_pkg::desc_type                q_head,
   output logic                                q_pop,
   output logic                                ram_re,
   output logic [$clog2(MAX_PAYLOAD+3):0]      ram_raddr,
   input  logic [7:0]                          ram_rdata,
   output logic                                frame_done,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_out_byte,
   output logic                                rsp_is_control,
   output logic                                rsp_last,
   output logic [2:0]                          rsp_status,
   output logic [ash_fd_pkg::PLEN_W-1:0]       rsp_payload_len,
   output logic [ash_fd_pkg::RAW_W-1:0]        rsp_raw_consumed
);

   localparam int STORE_DEPTH = MAX_PAYLOAD + 3;
   localparam int IW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EMIT,
      S_ERR
   } state_type;

   state_type                       state_ff, state_in;
   ash_fd_pkg::desc_type            desc_ff, desc_in;
   logic [CW-1:0]                   idx_ff, idx_in;
   logic                            valid_ff, valid_in;
   logic [7:0]                      byte_ff, byte_in;
   logic                            ctl_ff, ctl_in;
   logic                            last_ff, last_in;
   logic [2:0]                      status_ff, status_in;
   logic [ash_fd_pkg::PLEN_W-1:0]   plen_ff, plen_in;
   logic [ash_fd_pkg::RAW_W-1:0]    raw_ff, raw_in;
   logic                            out_free;
   logic                            is_last;

   assign out_free  = !valid_ff || !rsp_stall;
   assign is_last   = (idx_ff == CW'(desc_ff.plen));
   assign ram_raddr = {desc_ff.bank, idx_ff[IW-1:0]};

   always_comb begin
      state_in   = state_ff;
      desc_in    = desc_ff;
      idx_in     = idx_ff;
      valid_in   = valid_ff && rsp_stall;
      byte_in    = byte_ff;
      ctl_in     = ctl_ff;
      last_in    = last_ff;
      status_in  = status_ff;
      plen_in    = plen_ff;
      raw_in     = raw_ff;
      q_pop      = 1'b0;
      ram_re     = 1'b0;
      frame_done = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               desc_in = q_head;
               idx_in  = '0;
               state_in = (q_head.status == ash_fd_pkg::STATUS_OK) ? S_READ : S_ERR;
            end
         end
         S_READ: begin
            ram_re   = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               valid_in  = 1'b1;
               byte_in   = ram_rdata;
               ctl_in    = (idx_ff == '0);
               last_in   = is_last;
               status_in = ash_fd_pkg::STATUS_OK;
               plen_in   = desc_ff.plen;
               raw_in    = desc_ff.raw;
               if (is_last) begin
                  // bank is free once its last byte is read out
                  frame_done = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_ERR: begin
            if (out_free) begin
               valid_in   = 1'b1;
               byte_in    = '0;
               ctl_in     = 1'b0;
               last_in    = 1'b1;
               status_in  = desc_ff.status;
               plen_in    = '0;
               raw_in     = desc_ff.raw;
               frame_done = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      desc_ff   <= desc_in;
      idx_ff    <= idx_in;
      byte_ff   <= byte_in;
      ctl_ff    <= ctl_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      plen_ff   <= plen_in;
      raw_ff    <= raw_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_is_control   = ctl_ff;
   assign rsp_last         = last_ff;
   assign rsp_status       = status_ff;
   assign rsp_payload_len  = plen_ff;
   assign rsp_raw_consumed = raw_ff;

endmodule

// File: hw/rtl/ash_frame_decoder_top.sv
// Channel  | Direction | Handshake          | Payload
// req      | in        | req_valid/stall    | raw_byte
// rsp      | out       | rsp_valid/stall    | out_byte, is_control, last, status,
//          |           |                    | payload_len, raw_consumed
// csr      | in        | APB psel/penable   | payload_capacity at byte address 0
//
// The front takes one raw byte per cycle while a frame bank is free; req_stall rises
// while both banks hold frames whose bytes are not yet all read out of the RAM.
// For each good-frame result the back reads the RAM, then loads the result; each frame also passes
// through idle, and an error frame loads its result from the error state; the RAM read port is registered.
// Synchronous reset clears all control state; no clearing pass.
// A stalled result holds in the output register while the front keeps accepting until both banks are full.
// Depends on ash_fd_pkg, ash_fd_front, ash_fd_queue, ash_fd_back, ash_fd_ram.
`timescale 1ns / 1ps

module ash_frame_decoder_top #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_raw_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_is_control,
   output logic                              rsp_last,
   output logic [2:0]                        rsp_status,
   output logic [ash_fd_pkg::PLEN_W-1:0]     rsp_payload_len,
   output logic [ash_fd_pkg::RAW_W-1:0]      rsp_raw_consumed,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [2:0]                        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam int STORE_DEPTH = MAX_PAYLOAD + 3;
   localparam int AW = $clog2(STORE_DEPTH) + 1;

   logic [ash_fd_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic                         csr_write;
   logic                         ram_we;
   logic [AW-1:0]                ram_waddr;
   logic [7:0]                   ram_wdata;
   logic                         ram_re;
   logic [AW-1:0]                ram_raddr;
   logic [7:0]                   ram_rdata;
   logic                         q_push;
   logic                         q_pop;
   logic                         q_empty;
   ash_fd_pkg::desc_type         q_data;
   ash_fd_pkg::desc_type         q_head;
   logic                         frame_done;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cap_in     = (csr_write && csr_paddr[2] == ash_fd_pkg::REG_CAPACITY) ?
                       csr_pwdata[ash_fd_pkg::CAP_W-1:0] : cap_ff;
   assign csr_prdata = (csr_paddr[2] == ash_fd_pkg::REG_CAPACITY) ? 32'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= ash_fd_pkg::CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   ash_fd_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_raw_byte (req_raw_byte),
      .req_stall    (req_stall),
      .capacity     (cap_ff),
      .ram_we       (ram_we),
      .ram_waddr    (ram_waddr),
      .ram_wdata    (ram_wdata),
      .q_push       (q_push),
      .q_data       (q_data),
      .frame_done   (frame_done)
   );

   ash_fd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   ash_fd_ram #(
      .WIDTH (8),
      .DEPTH (1 << AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ash_fd_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .ram_re           (ram_re),
      .ram_raddr        (ram_raddr),
      .ram_rdata        (ram_rdata),
      .frame_done       (frame_done),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_is_control   (rsp_is_control),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status),
      .rsp_payload_len  (rsp_payload_len),
      .rsp_raw_consumed (rsp_raw_consumed)
   );

endmodule

// File: hw/rtl/ash_fd_checker.sv
// Port-level checks on the frame decoder results, bound to the top level.
// Depends on ash_frame_decoder_top_defines.svh and ash_fd_pkg.
`timescale 1ns / 1ps
`include "ash_frame_decoder_top_defines.svh"

module ash_fd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [7:0]                    rsp_out_byte,
   input logic                          rsp_is_control,
   input logic                          rsp_last,
   input logic [2:0]                    rsp_status,
   input logic [ash_fd_pkg::PLEN_W-1:0] rsp_payload_len
);

   // hold a stalled result
   `ASH_FD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_out_byte) && $stable(rsp_status) && $stable(rsp_last))

   // an error is a single, empty, closing result
   `ASH_FD_ASSERT_NOW(a_err_shape, clock, reset,
      rsp_valid && rsp_status != ash_fd_pkg::STATUS_OK,
      rsp_last && !rsp_is_control && rsp_out_byte == 8'h00 && rsp_payload_len == '0)

   // control byte only on a good frame
   `ASH_FD_ASSERT_NOW(a_ctl_ok, clock, reset, rsp_valid && rsp_is_control,
      rsp_status == ash_fd_pkg::STATUS_OK)

   // a control byte that closes the frame means an empty payload
   `ASH_FD_ASSERT_NOW(a_ctl_last, clock, reset,
      rsp_valid && rsp_is_control && rsp_last, rsp_payload_len == '0)

endmodule

bind ash_frame_decoder_top ash_fd_checker u_checker (.*);
